@@ rtl/rta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_pkg
// Shared types, constants and helpers for the radix to ASCII digit converter.
// ----------------------------------------------------------------------------
package rta_pkg;

	localparam int unsigned DEF_VALUE_WIDTH = 32;
	localparam int unsigned STEP_BITS       = 8;

	localparam logic [7:0] RADIX_RESET = 8'd10;
	localparam logic [7:0] MIN_RADIX   = 8'd2;
	localparam logic [7:0] MAX_RADIX   = 8'd16;

	localparam logic [6:0] ASCII_ZERO        = 7'd48;
	localparam logic [6:0] ASCII_LETTER_BIAS = 7'd55;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} rta_state_t;

	typedef struct packed {
		logic       done;
		logic [3:0] rem;
	} rta_div_stat_t;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic [3:0] digit;
	} rta_stack_ctl_t;

	function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
		logic [6:0] d7;
		d7 = {3'b000, d};
		return (d >= 4'd10) ? (d7 + ASCII_LETTER_BIAS) : (d7 + ASCII_ZERO);
	endfunction

endpackage

@@ rtl/rta_div_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_div_unit
// Shared divider: divides a word by the radix, one byte of dividend a cycle.
// ----------------------------------------------------------------------------
module rta_div_unit
	import rta_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [4:0]             radix,
	output logic [VALUE_WIDTH-1:0] quotient,
	output rta_div_stat_t          stat
);

	localparam int unsigned CHUNKS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
	localparam int unsigned PAD_W  = CHUNKS * STEP_BITS;
	localparam int unsigned CNT_W  = $clog2(CHUNKS + 1);

	logic [PAD_W-1:0]           work_q;
	logic [3:0]                 rem_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       active_q;
	logic                       done_q;
	logic [STEP_BITS-1:0]       qbyte;
	logic [3:0]                 rem_d;
	logic [PAD_W+STEP_BITS-1:0] shifted;
	logic                       last;

	// restoring division over one byte
	always_comb begin
		logic [STEP_BITS-1:0] chunk;
		logic [4:0]           t;
		chunk = work_q[PAD_W-1 -: STEP_BITS];
		rem_d = rem_q;
		qbyte = '0;
		for (int i = STEP_BITS - 1; i >= 0; i--) begin
			t = {rem_d, chunk[i]};
			if (t >= radix) begin
				qbyte[i] = 1'b1;
				t        = t - radix;
			end
			rem_d = t[3:0];
		end
	end

	assign shifted = {work_q, qbyte};
	assign last    = (cnt_q == CNT_W'(CHUNKS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else if (active_q) begin
			active_q <= !last;
			done_q   <= last;
			cnt_q    <= cnt_q + 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= PAD_W'(dividend);
			rem_q  <= '0;
		end else if (active_q) begin
			work_q <= shifted[PAD_W-1:0];
			rem_q  <= rem_d;
		end
	end

	assign quotient  = work_q[VALUE_WIDTH-1:0];
	assign stat.done = done_q;
	assign stat.rem  = rem_q;

endmodule

@@ rtl/rta_digit_stack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_digit_stack
// Last-in first-out shift line holding digits until they are sent out.
// ----------------------------------------------------------------------------
module rta_digit_stack
	import rta_pkg::*;
#(
	parameter int unsigned DEPTH = DEF_VALUE_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rta_stack_ctl_t             ctl,
	output logic [3:0]                 top_digit,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [3:0]       slot_q [DEPTH];
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			slot_q[0] <= ctl.digit;
			for (int i = 1; i < DEPTH; i++) begin
				slot_q[i] <= slot_q[i-1];
			end
		end else if (ctl.pop) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				slot_q[i] <= slot_q[i+1];
			end
			slot_q[DEPTH-1] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.push) begin
			count_q <= count_q + 1'b1;
		end else if (ctl.pop) begin
			count_q <= count_q - 1'b1;
		end
	end

	assign top_digit = slot_q[0];
	assign count     = count_q;

endmodule

@@ rtl/radix_to_ascii_digits.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_to_ascii_digits
// Converts an unsigned word into ASCII digits in base 2 to 16, most
// significant first, flagging the last digit. One divider is reused per digit.
// Each digit takes one pass of the divider and is pushed onto a digit stack;
// the digits are then popped and sent, most significant first,
// so the first digit follows the last division.
// A base outside 2 to 16 drops the word; busy stays low.
// Results cannot be stalled. Asynchronous reset sets the radix to 10 and idles.
// ----------------------------------------------------------------------------
module radix_to_ascii_digits
	import rta_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [31:0]            value,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [7:0]             cfg_data,
	output logic                   digit_valid,
	output logic [6:0]             digit_char,
	output logic                   is_last
);

	localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

	rta_state_t             state_q, state_d;
	logic [7:0]             radix_q;
	logic                   radix_ok;
	logic                   div_start;
	logic [VALUE_WIDTH-1:0] dividend;
	logic [VALUE_WIDTH-1:0] quotient;
	rta_div_stat_t          div_stat;
	rta_stack_ctl_t         stack_ctl;
	logic [3:0]             top_digit;
	logic [CNT_W-1:0]       count;
	logic                   valid_q;
	logic [6:0]             char_q;
	logic                   last_q;

	assign cfg_ready = !busy;
	assign busy      = (state_q != ST_IDLE);
	assign radix_ok  = (radix_q >= MIN_RADIX) && (radix_q <= MAX_RADIX);
	assign dividend  = (state_q == ST_IDLE) ? VALUE_WIDTH'(value) : quotient;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= cfg_data;
		end
	end

	rta_div_unit #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(dividend),
		.radix   (radix_q[4:0]),
		.quotient(quotient),
		.stat    (div_stat)
	);

	rta_digit_stack #(
		.DEPTH(VALUE_WIDTH)
	) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (stack_ctl),
		.top_digit(top_digit),
		.count    (count)
	);

	// sequencer
	always_comb begin
		state_d         = state_q;
		div_start       = 1'b0;
		stack_ctl.push  = 1'b0;
		stack_ctl.pop   = 1'b0;
		stack_ctl.digit = div_stat.rem;
		case (state_q)
			ST_IDLE: begin
				if (start && radix_ok) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					stack_ctl.push = 1'b1;
					if (quotient == '0) begin
						state_d = ST_EMIT;
					end else begin
						div_start = 1'b1;
					end
				end
			end
			ST_EMIT: begin
				stack_ctl.pop = 1'b1;
				if (count == CNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			char_q <= digit_to_ascii(top_digit);
			last_q <= (count == CNT_W'(1));
		end
	end

	assign digit_valid = valid_q;
	assign digit_char  = char_q;
	assign is_last     = last_q;

`ifndef NO_ASSERTIONS
	// every sent digit is a legal digit character
	assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid |-> ((digit_char >= 7'd48 && digit_char <= 7'd57) ||
		                 (digit_char >= 7'd65 && digit_char <= 7'd70)))
		else $error("digit character out of range");

	// sending never starts from an empty stack
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (count != '0))
		else $error("emit with empty digit stack");

	// the last digit closes the run
	assert property (@(posedge clk) disable iff (!arst_n)
		(digit_valid && is_last) |=> !digit_valid)
		else $error("digit sent after end of run");

	// an invalid base drops the word at once
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !radix_ok) |=> !busy)
		else $error("busy raised for invalid radix");

	// digits are pushed only by a finished division
	assert property (@(posedge clk) disable iff (!arst_n)
		stack_ctl.push |-> (state_q == ST_DIV && div_stat.done))
		else $error("push without finished division");
`endif

endmodule

@@ test/tb_radix_to_ascii_digits.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix_to_ascii_digits
// Self-checking bench for the radix to ASCII digit converter. Each accepted
// word is converted in the bench into its expected digit string under the
// radix currently held, and every digit strobe is checked against the oldest
// expected character and last-digit flag. Directed tests cover the reset
// radix, field extremes, hex letters and out-of-range bases; a random phase
// then sweeps bases and values with random gaps between words.
// ----------------------------------------------------------------------------
module tb_radix_to_ascii_digits;
	import rta_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_WORDS   = 200;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		logic [6:0] ch;
		logic       last;
	} digit_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] value;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;
	logic        digit_valid;
	logic [6:0]  digit_char;
	logic        is_last;

	digit_t      expected_digits[$];
	logic [7:0]  radix_setting;
	int          err_count;
	int          idle_cycles;
	bit          steady_phase;

	radix_to_ascii_digits dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.digit_valid (digit_valid),
		.digit_char  (digit_char),
		.is_last     (is_last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic bit radix_in_range(input logic [7:0] r);
		return (r >= MIN_RADIX) && (r <= MAX_RADIX);
	endfunction

	// digit string of one word, most significant first
	function automatic void predict_digits(input logic [31:0] v);
		logic [3:0]  digs [32];
		logic [31:0] rest;
		logic [6:0]  ch;
		digit_t      d;
		int          n;
		if (!radix_in_range(radix_setting))
			return;
		if (v == 32'd0) begin
			d.ch   = 7'h30;
			d.last = 1'b1;
			expected_digits.push_back(d);
			return;
		end
		rest = v;
		n    = 0;
		while (rest != 32'd0) begin
			digs[n] = 4'(rest % radix_setting);
			rest    = rest / radix_setting;
			n++;
		end
		for (int k = n - 1; k >= 0; k--) begin
			if (digs[k] < 4'd10)
				ch = 7'h30 + 7'(digs[k]);
			else
				ch = 7'h41 + 7'(digs[k]) - 7'd10;
			d.ch   = ch;
			d.last = (k == 0);
			expected_digits.push_back(d);
		end
	endfunction

	function automatic void note_fail(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("mismatch at %0t: %s", $realtime, msg);
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady_phase)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// values near powers of the base stress the digit count
	function automatic logic [31:0] pick_value(input logic [7:0] r);
		logic [63:0] p;
		int          k;
		case ($urandom_range(0, 9))
			0, 1: return $urandom_range(0, 300);
			2, 3: return $urandom;
			4, 5: begin
				if (r < 2)
					return $urandom;
				p = 64'd1;
				k = $urandom_range(1, 32);
				repeat (k)
					if (p * r < 64'h1_0000_0000)
						p = p * r;
				case ($urandom_range(0, 2))
					0: return 32'(p - 64'd1);
					1: return 32'(p);
					default: return 32'(p + 64'd1);
				endcase
			end
			6: begin
				case ($urandom_range(0, 2))
					0: return 32'hFFFF_FFFF;
					1: return 32'h8000_0000;
					default: return 32'h0000_0000;
				endcase
			end
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	// send one word; returns on the accepting edge with start still high
	task automatic send_value(input logic [31:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		predict_digits(v);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (expected_digits.size() != 0)
			@(posedge clk);
		do @(posedge clk); while (busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_radix(input logic [7:0] r);
		wait_drained();
		repeat (pick_gap()) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= r;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid     <= 1'b0;
		radix_setting  = r;
	endtask

	task automatic test_reset_radix();
		send_value(32'd0);
		send_value(32'd9);
		send_value(32'd10);
		send_value(32'd99);
		send_value(32'd100);
		send_value(32'hFFFF_FFFF);
	endtask

	task automatic test_binary_extremes();
		write_radix(8'd2);
		send_value(32'd0);
		send_value(32'd1);
		send_value(32'hFFFF_FFFF);
		send_value(32'h8000_0000);
	endtask

	task automatic test_hex_letters();
		write_radix(8'd16);
		send_value(32'hFFFF_FFFF);
		send_value(32'hABCD_EF01);
		send_value(32'd16);
	endtask

	task automatic test_bad_radix();
		write_radix(8'd0);
		send_value(32'd123);
		write_radix(8'd1);
		send_value(32'd5);
		write_radix(8'd17);
		send_value(32'd0);
		write_radix(8'd255);
		send_value(32'hFFFF_FFFF);
	endtask

	task automatic test_random_words();
		logic [7:0] r;
		int         sent;
		int         phase_len;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			if ($urandom_range(0, 99) < 85)
				r = 8'($urandom_range(2, 16));
			else if ($urandom_range(0, 1) == 0)
				r = 8'($urandom_range(0, 1));
			else
				r = 8'($urandom_range(17, 255));
			write_radix(r);
			steady_phase = ($urandom_range(0, 3) == 0);
			phase_len    = radix_in_range(r) ? $urandom_range(5, 25) : $urandom_range(2, 5);
			for (int i = 0; i < phase_len; i++) begin
				send_value(pick_value(r));
				if (radix_in_range(r))
					sent++;
			end
			steady_phase = 1'b0;
		end
	endtask

	always @(posedge clk) begin : check_digits
		digit_t exp_d;
		if (arst_n && digit_valid) begin
			if (expected_digits.size() == 0) begin
				note_fail($sformatf("unexpected digit char=%h last=%b", digit_char, is_last));
			end else begin
				exp_d = expected_digits.pop_front();
				if (digit_char !== exp_d.ch)
					note_fail($sformatf("char expected %h got %h", exp_d.ch, digit_char));
				else if (is_last !== exp_d.last)
					note_fail($sformatf("last flag expected %b got %b", exp_d.last, is_last));
			end
		end
	end

	// no word moved for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || digit_valid || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		value         = 32'd0;
		cfg_valid     = 1'b0;
		cfg_data      = 8'd0;
		err_count     = 0;
		idle_cycles   = 0;
		steady_phase  = 1'b0;
		radix_setting = RADIX_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_radix();
		test_binary_extremes();
		test_hex_letters();
		test_bad_radix();
		test_random_words();

		wait_drained();
		repeat (20) @(posedge clk);
		if (expected_digits.size() != 0)
			err_count++;
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ radix_to_ascii_digits.f @@
rtl/rta_pkg.sv
rtl/rta_div_unit.sv
rtl/rta_digit_stack.sv
rtl/radix_to_ascii_digits.sv
test/tb_radix_to_ascii_digits.sv
